[sv/svoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svoa_pkg
// Shared constants, operation codes and types of the sound voice allocator.
// ----------------------------------------------------------------------------
package svoa_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int NUM_SOUNDS_DEF   = 256;
	localparam int LENGTH_BITS_DEF  = 24;

	localparam logic [2:0] OP_REGISTER   = 3'd0;
	localparam logic [2:0] OP_PLAY       = 3'd1;
	localparam logic [2:0] OP_END        = 3'd2;
	localparam logic [2:0] OP_CLR_STAGE  = 3'd3;
	localparam logic [2:0] OP_CLR_GLOBAL = 3'd4;

	localparam logic [1:0] SCP_EMPTY = 2'd0;
	localparam logic [1:0] SCP_WORLD = 2'd1;
	localparam logic [1:0] SCP_LEVEL = 2'd2;

	localparam logic [31:0] LEN_NEVER_STEAL = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_REG_SCAN,
		ST_CLR_SCAN,
		ST_PLAY_SND,
		ST_PLAY_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic beat;
	} scan_ctl_t;

endpackage

[sv/svoa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svoa_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module svoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/svoa_chan_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svoa_chan_scan
// Accumulates instance count, oldest instance and steal candidate over one
// walk of the channel table.
// ----------------------------------------------------------------------------
module svoa_chan_scan #(
	parameter int NUM_CHANNELS = svoa_pkg::NUM_CHANNELS_DEF,
	parameter int SND_BITS     = 8,
	parameter int LENGTH_BITS  = svoa_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  svoa_pkg::scan_ctl_t               ctl,
	input  logic [$clog2(NUM_CHANNELS)-1:0]   idx,
	input  logic                              ent_busy,
	input  logic [SND_BITS-1:0]               ent_sound,
	input  logic [LENGTH_BITS-1:0]            ent_length,
	input  logic [7:0]                        ent_prio,
	input  logic [31:0]                       ent_index,
	input  logic [SND_BITS-1:0]               req_sound,
	input  logic [7:0]                        req_prio,
	input  logic [31:0]                       play_count,
	output logic [$clog2(NUM_CHANNELS+1)-1:0] count,
	output logic                              old_found,
	output logic [$clog2(NUM_CHANNELS)-1:0]   old_idx,
	output logic                              steal_found,
	output logic [$clog2(NUM_CHANNELS)-1:0]   steal_idx
);

	localparam int CAW = $clog2(NUM_CHANNELS);
	localparam int CW  = $clog2(NUM_CHANNELS + 1);

	logic [CW-1:0]          count_q;
	logic [31:0]            best_age_q;
	logic                   old_found_q;
	logic [CAW-1:0]         old_idx_q;
	logic [LENGTH_BITS-1:0] best_len_q;
	logic                   steal_found_q;
	logic [CAW-1:0]         steal_idx_q;

	logic        same;
	logic [31:0] age;
	logic        take_old;
	logic        take_steal;

	always_comb begin
		same     = ent_busy && (ent_sound == req_sound);
		age      = play_count - ent_index;
		take_old = same && !age[31] && (age > best_age_q);
		// ties keep the earlier channel; only lower-priority entries are stolen
		take_steal = (req_prio > ent_prio) &&
			(steal_found_q ? (ent_length < best_len_q)
			               : (32'(ent_length) != svoa_pkg::LEN_NEVER_STEAL));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			best_age_q    <= '0;
			old_found_q   <= 1'b0;
			old_idx_q     <= '0;
			best_len_q    <= '0;
			steal_found_q <= 1'b0;
			steal_idx_q   <= '0;
		end else if (ctl.start) begin
			count_q       <= '0;
			best_age_q    <= '0;
			old_found_q   <= 1'b0;
			old_idx_q     <= '0;
			best_len_q    <= '0;
			steal_found_q <= 1'b0;
			steal_idx_q   <= '0;
		end else if (ctl.beat) begin
			if (same) begin
				count_q <= count_q + CW'(1);
			end
			if (take_old) begin
				best_age_q  <= age;
				old_found_q <= 1'b1;
				old_idx_q   <= idx;
			end
			if (take_steal) begin
				best_len_q    <= ent_length;
				steal_found_q <= 1'b1;
				steal_idx_q   <= idx;
			end
		end
	end

	assign count       = count_q;
	assign old_found   = old_found_q;
	assign old_idx     = old_idx_q;
	assign steal_found = steal_found_q;
	assign steal_idx   = steal_idx_q;

endmodule

[sv/sound_voice_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_voice_allocator
// Sound table and channel table manager that hands out mixer voices.
// ----------------------------------------------------------------------------
// Usage:
//   One request channel (in_valid/in_ready) carries op and its operands; one
//   result channel (out_valid/out_ready) returns status, chosen_channel,
//   loop_value and sound_slot, one result per request, in order.
//   The block works on one request at a time; in_ready is high only while no
//   request is in flight. A finished result sits in the output register, so
//   a new request is taken while the receiver still stalls on the last one.
//   Work per request: channel ended and unknown op need no table walk; play
//   walks the channel memory through its one read port, one entry a cycle;
//   register and clear stage/global walk the sound memory through its
//   single read port; register skips it for an empty scope and may stop it early.
//   After reset the block sweeps the sound memory to zero with in_ready
//   low; channels come up free through their busy flops. When out_ready
//   stays low, a finished result waits in the done state until the output
//   register drains.
// ----------------------------------------------------------------------------
module sound_voice_allocator #(
	parameter int NUM_CHANNELS = svoa_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_SOUNDS   = svoa_pkg::NUM_SOUNDS_DEF,
	parameter int LENGTH_BITS  = svoa_pkg::LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic [7:0]         sound_id,
	input  logic [7:0]         priority_req,
	input  logic [30:0]        loop_point,
	input  logic [7:0]         max_plays,
	input  logic [1:0]         scope,
	input  logic [23:0]        sample_length,
	input  logic [3:0]         channel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [3:0]         chosen_channel,
	output logic signed [31:0] loop_value,
	output logic [7:0]         sound_slot
);

	localparam int CAW  = $clog2(NUM_CHANNELS);
	localparam int CCW  = $clog2(NUM_CHANNELS + 1);
	localparam int SAW  = $clog2(NUM_SOUNDS);
	localparam int SCW  = $clog2(NUM_SOUNDS + 1);
	localparam int CW   = $clog2(NUM_CHANNELS + 1);
	// sound entry: {scope, max plays, length, play counter}
	localparam int SNDW = 2 + 8 + LENGTH_BITS + 32;
	// channel entry: {sound, length, priority, play index}
	localparam int CHW  = SAW + LENGTH_BITS + 8 + 32;

	svoa_pkg::state_t state_q, state_d;

	// request operands, held for the whole operation
	logic [2:0]  op_q;
	logic [7:0]  snd_q;
	logic [7:0]  prio_q;
	logic [30:0] loop_q;
	logic [7:0]  plays_q;
	logic [1:0]  scope_q;
	logic [23:0] len_q;

	// sound entry of the sound being played
	logic [1:0]             ent_scope_q;
	logic [7:0]             ent_max_q;
	logic [LENGTH_BITS-1:0] ent_len_q;
	logic [31:0]            ent_cnt_q;

	logic [NUM_CHANNELS-1:0] busy_q;

	logic [SCW-1:0] snd_cnt_q;
	logic           snd_beat_s1;
	logic [SAW-1:0] snd_addr_s1;
	logic [CCW-1:0] ch_cnt_q;
	logic           ch_beat_s1;
	logic [CAW-1:0] ch_addr_s1;

	logic           res_status_q;
	logic [CAW-1:0] res_chan_q;
	logic [7:0]     res_slot_q;

	logic               out_valid_q;
	logic               out_status_q;
	logic [3:0]         out_chan_q;
	logic signed [31:0] out_loop_q;
	logic [7:0]         out_slot_q;

	logic            snd_we;
	logic [SAW-1:0]  snd_waddr;
	logic [SNDW-1:0] snd_wdata;
	logic [SAW-1:0]  snd_raddr;
	logic [SNDW-1:0] snd_rdata;
	logic            ch_we;
	logic [CHW-1:0]  ch_wdata;
	logic [CAW-1:0]  ch_raddr;
	logic [CHW-1:0]  ch_rdata;

	logic [1:0] rd_scope;
	logic       snd_issue;
	logic       ch_issue;
	logic       snd_scan_go;
	logic       ch_scan_go;

	svoa_pkg::scan_ctl_t scan_ctl;
	logic [CW-1:0]       scan_count;
	logic                old_found;
	logic [CAW-1:0]      old_idx;
	logic                steal_found;
	logic [CAW-1:0]      steal_idx;

	logic           free_found;
	logic [CAW-1:0] free_idx;
	logic           pick_found;
	logic [CAW-1:0] pick_idx;

	logic           res_load;
	logic           res_status_d;
	logic [CAW-1:0] res_chan_d;
	logic [7:0]     res_slot_d;
	logic           busy_set;
	logic           busy_clr_one;
	logic           busy_clr_all;
	logic           out_load;
	logic [31:0]    loopv;

	assign in_ready = (state_q == svoa_pkg::ST_IDLE);
	assign rd_scope = snd_rdata[LENGTH_BITS+41:LENGTH_BITS+40];

	assign snd_issue = ((state_q == svoa_pkg::ST_REG_SCAN) ||
		(state_q == svoa_pkg::ST_CLR_SCAN)) && (snd_cnt_q != SCW'(NUM_SOUNDS));
	assign ch_issue = (state_q == svoa_pkg::ST_PLAY_SCAN) &&
		(ch_cnt_q != CCW'(NUM_CHANNELS));

	svoa_ram #(
		.WIDTH (SNDW),
		.DEPTH (NUM_SOUNDS)
	) u_snd_ram (
		.clk   (clk),
		.we    (snd_we),
		.waddr (snd_waddr),
		.wdata (snd_wdata),
		.raddr (snd_raddr),
		.rdata (snd_rdata)
	);

	svoa_ram #(
		.WIDTH (CHW),
		.DEPTH (NUM_CHANNELS)
	) u_ch_ram (
		.clk   (clk),
		.we    (ch_we),
		.waddr (pick_idx),
		.wdata (ch_wdata),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	svoa_chan_scan #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SND_BITS     (SAW),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.idx         (ch_addr_s1),
		.ent_busy    (busy_q[ch_addr_s1]),
		.ent_sound   (ch_rdata[CHW-1:LENGTH_BITS+40]),
		.ent_length  (ch_rdata[LENGTH_BITS+39:40]),
		.ent_prio    (ch_rdata[39:32]),
		.ent_index   (ch_rdata[31:0]),
		.req_sound   (SAW'(snd_q)),
		.req_prio    (prio_q),
		.play_count  (ent_cnt_q),
		.count       (scan_count),
		.old_found   (old_found),
		.old_idx     (old_idx),
		.steal_found (steal_found),
		.steal_idx   (steal_idx)
	);

	// first free channel, lowest index wins
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = CAW'(i);
			end
		end
	end

	// channel choice: oldest instance at the limit, then free, then steal
	always_comb begin
		pick_found = 1'b1;
		pick_idx   = steal_idx;
		if ((32'(scan_count) >= 32'(ent_max_q)) && old_found) begin
			pick_idx = old_idx;
		end else if (free_found) begin
			pick_idx = free_idx;
		end else if (!steal_found) begin
			pick_found = 1'b0;
		end
	end

	assign ch_wdata = {SAW'(snd_q), ent_len_q, prio_q, ent_cnt_q};

	always_comb begin
		state_d      = state_q;
		snd_raddr    = snd_cnt_q[SAW-1:0];
		snd_we       = 1'b0;
		snd_waddr    = snd_addr_s1;
		snd_wdata    = '0;
		ch_raddr     = ch_cnt_q[CAW-1:0];
		ch_we        = 1'b0;
		res_load     = 1'b0;
		res_status_d = 1'b1;
		res_chan_d   = '0;
		res_slot_d   = '0;
		busy_set     = 1'b0;
		busy_clr_one = 1'b0;
		busy_clr_all = 1'b0;
		snd_scan_go  = 1'b0;
		ch_scan_go   = 1'b0;
		scan_ctl     = '{start: 1'b0, beat: ch_beat_s1};
		case (state_q)
			svoa_pkg::ST_INIT: begin
				// sweep the sound table to zero after reset
				snd_we    = 1'b1;
				snd_waddr = snd_cnt_q[SAW-1:0];
				if (snd_cnt_q == SCW'(NUM_SOUNDS - 1)) begin
					state_d = svoa_pkg::ST_IDLE;
				end
			end
			svoa_pkg::ST_IDLE: begin
				snd_raddr = SAW'(sound_id);
				if (in_valid) begin
					case (op)
						svoa_pkg::OP_REGISTER: begin
							if (scope == svoa_pkg::SCP_EMPTY) begin
								res_load = 1'b1;
								state_d  = svoa_pkg::ST_DONE;
							end else begin
								snd_scan_go = 1'b1;
								state_d     = svoa_pkg::ST_REG_SCAN;
							end
						end
						svoa_pkg::OP_PLAY: begin
							if (int'(sound_id) < NUM_SOUNDS) begin
								state_d = svoa_pkg::ST_PLAY_SND;
							end else begin
								res_load = 1'b1;
								state_d  = svoa_pkg::ST_DONE;
							end
						end
						svoa_pkg::OP_END: begin
							busy_clr_one = (int'(channel) < NUM_CHANNELS);
							res_load     = 1'b1;
							res_status_d = 1'b0;
							state_d      = svoa_pkg::ST_DONE;
						end
						svoa_pkg::OP_CLR_STAGE, svoa_pkg::OP_CLR_GLOBAL: begin
							busy_clr_all = 1'b1;
							snd_scan_go  = 1'b1;
							state_d      = svoa_pkg::ST_CLR_SCAN;
						end
						default: begin
							res_load = 1'b1;
							state_d  = svoa_pkg::ST_DONE;
						end
					endcase
				end
			end
			svoa_pkg::ST_REG_SCAN: begin
				if (snd_beat_s1 && (rd_scope == svoa_pkg::SCP_EMPTY)) begin
					snd_we       = 1'b1;
					snd_wdata    = {scope_q, plays_q, LENGTH_BITS'(len_q), 32'd0};
					res_load     = 1'b1;
					res_status_d = 1'b0;
					res_slot_d   = 8'(snd_addr_s1);
					state_d      = svoa_pkg::ST_DONE;
				end else if (!snd_beat_s1 && (snd_cnt_q == SCW'(NUM_SOUNDS))) begin
					res_load = 1'b1;
					state_d  = svoa_pkg::ST_DONE;
				end
			end
			svoa_pkg::ST_CLR_SCAN: begin
				if (snd_beat_s1 &&
				    (((op_q == svoa_pkg::OP_CLR_STAGE) &&
				      (rd_scope >= svoa_pkg::SCP_LEVEL)) ||
				     ((op_q == svoa_pkg::OP_CLR_GLOBAL) &&
				      (rd_scope == svoa_pkg::SCP_WORLD)))) begin
					snd_we = 1'b1;
				end
				if (!snd_beat_s1 && (snd_cnt_q == SCW'(NUM_SOUNDS))) begin
					res_load     = 1'b1;
					res_status_d = 1'b0;
					state_d      = svoa_pkg::ST_DONE;
				end
			end
			svoa_pkg::ST_PLAY_SND: begin
				if (rd_scope == svoa_pkg::SCP_EMPTY) begin
					res_load = 1'b1;
					state_d  = svoa_pkg::ST_DONE;
				end else begin
					ch_scan_go     = 1'b1;
					scan_ctl.start = 1'b1;
					state_d        = svoa_pkg::ST_PLAY_SCAN;
				end
			end
			svoa_pkg::ST_PLAY_SCAN: begin
				if (!ch_beat_s1 && (ch_cnt_q == CCW'(NUM_CHANNELS))) begin
					res_load = 1'b1;
					state_d  = svoa_pkg::ST_DONE;
					if (pick_found) begin
						// claim the channel and bump the sound's play counter
						ch_we        = 1'b1;
						snd_we       = 1'b1;
						snd_waddr    = SAW'(snd_q);
						snd_wdata    = {ent_scope_q, ent_max_q, ent_len_q,
							ent_cnt_q + 32'd1};
						busy_set     = 1'b1;
						res_status_d = 1'b0;
						res_chan_d   = pick_idx;
					end
				end
			end
			svoa_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = svoa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = svoa_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_load = (state_q == svoa_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign loopv    = (loop_q >= 31'd2) ? 32'(loop_q) : (32'(loop_q) - 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svoa_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counters and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snd_cnt_q   <= '0;
			snd_beat_s1 <= 1'b0;
			ch_cnt_q    <= '0;
			ch_beat_s1  <= 1'b0;
		end else begin
			if (snd_scan_go) begin
				snd_cnt_q <= '0;
			end else if ((state_q == svoa_pkg::ST_INIT) || snd_issue) begin
				snd_cnt_q <= snd_cnt_q + SCW'(1);
			end
			snd_beat_s1 <= snd_issue && !snd_scan_go;
			if (ch_scan_go) begin
				ch_cnt_q <= '0;
			end else if (ch_issue) begin
				ch_cnt_q <= ch_cnt_q + CCW'(1);
			end
			ch_beat_s1 <= ch_issue && !ch_scan_go;
		end
	end

	always_ff @(posedge clk) begin
		snd_addr_s1 <= snd_cnt_q[SAW-1:0];
		ch_addr_s1  <= ch_cnt_q[CAW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (busy_clr_all) begin
			busy_q <= '0;
		end else if (busy_clr_one) begin
			busy_q[CAW'(channel)] <= 1'b0;
		end else if (busy_set) begin
			busy_q[pick_idx] <= 1'b1;
		end
	end

	// hold operands of the accepted request, the played sound's entry and the result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= op;
			snd_q   <= sound_id;
			prio_q  <= priority_req;
			loop_q  <= loop_point;
			plays_q <= max_plays;
			scope_q <= scope;
			len_q   <= sample_length;
		end
		if (state_q == svoa_pkg::ST_PLAY_SND) begin
			ent_scope_q <= rd_scope;
			ent_max_q   <= snd_rdata[LENGTH_BITS+39:LENGTH_BITS+32];
			ent_len_q   <= snd_rdata[LENGTH_BITS+31:32];
			ent_cnt_q   <= snd_rdata[31:0];
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_chan_q   <= res_chan_d;
			res_slot_q   <= res_slot_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_chan_q   <= 4'(res_chan_q);
			out_slot_q   <= res_slot_q;
			out_loop_q   <= ((op_q == svoa_pkg::OP_PLAY) && !res_status_q) ?
				loopv : 32'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign chosen_channel = out_chan_q;
	assign loop_value     = out_loop_q;
	assign sound_slot     = out_slot_q;

`ifndef SYNTHESIS
	a_play_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svoa_pkg::ST_DONE && op_q == svoa_pkg::OP_PLAY && !res_status_q)
		|-> busy_q[res_chan_q])
		else $error("granted channel is not marked busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == svoa_pkg::ST_DONE)
		else $error("result raised outside the done state");

	a_snd_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		snd_we |-> (state_q == svoa_pkg::ST_INIT || state_q == svoa_pkg::ST_REG_SCAN ||
			state_q == svoa_pkg::ST_CLR_SCAN || state_q == svoa_pkg::ST_PLAY_SCAN))
		else $error("sound table written in a state that owns no write");

	a_ch_beat_state: assert property (@(posedge clk) disable iff (!arst_n)
		ch_beat_s1 |-> state_q == svoa_pkg::ST_PLAY_SCAN)
		else $error("channel read returned outside the play walk");
`endif

endmodule
